### hw/rtl/rice_encoder_bit_packer_macros.svh
// ----------------------------------------------------------------------------
// Rice encoder assertion macros
// Shared concurrent assertion forms, clocked on clk_i, quiet during reset.
// ----------------------------------------------------------------------------
`ifndef RICE_ENCODER_BIT_PACKER_MACROS_SVH
`define RICE_ENCODER_BIT_PACKER_MACROS_SVH

// Check an implication or a plain property every cycle out of reset.
`define RE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that cause in one cycle brings effect in the next.
`define RE_ASSERT_NEXT(lbl, cause, effect, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cause) |=> (effect)) \
    else $error(msg);

`endif

### hw/rtl/rice_enc_pkg.sv
// ----------------------------------------------------------------------------
// Rice encoder package
// Input modes, microcode control word types and sequencer status.
// ----------------------------------------------------------------------------
package rice_enc_pkg;

  localparam int unsigned StepW = 4;

  localparam logic [1:0] MODE_SYM = 2'd0;
  localparam logic [1:0] MODE_HDR = 2'd1;
  localparam logic [1:0] MODE_PAD = 2'd2;

  typedef enum logic [1:0] {
    OP_FETCH,
    OP_LOAD,
    OP_RUN,
    OP_FIN
  } op_e;

  typedef enum logic [1:0] {
    SRC_ONES,
    SRC_REM,
    SRC_HDR,
    SRC_PAD
  } src_e;

  typedef struct packed {
    op_e  op;
    src_e src;
  } ctrl_t;

  typedef struct packed {
    op_e              op;
    src_e             src;
    logic [StepW-1:0] next;
  } ctrl_word_t;

  typedef struct packed {
    logic       in_fire;
    logic [1:0] mode;
    logic       advance;
  } seq_status_t;

endpackage

### hw/rtl/rice_enc_seq.sv
// ----------------------------------------------------------------------------
// Rice encoder sequencer
// Step counter over a fixed control program, with mode dispatch on fetch.
// ----------------------------------------------------------------------------
module rice_enc_seq import rice_enc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  seq_status_t status_i,
  output ctrl_t       ctrl_o
);

  localparam int unsigned NumSteps = 10;

  localparam logic [StepW-1:0] StFetch   = 4'd0;
  localparam logic [StepW-1:0] StOnesLd  = 4'd1;
  localparam logic [StepW-1:0] StOnesRun = 4'd2;
  localparam logic [StepW-1:0] StRemLd   = 4'd3;
  localparam logic [StepW-1:0] StRemRun  = 4'd4;
  localparam logic [StepW-1:0] StHdrLd   = 4'd5;
  localparam logic [StepW-1:0] StHdrRun  = 4'd6;
  localparam logic [StepW-1:0] StPadLd   = 4'd7;
  localparam logic [StepW-1:0] StPadRun  = 4'd8;
  localparam logic [StepW-1:0] StFin     = 4'd9;

  localparam ctrl_word_t Program [NumSteps] = '{
    '{op: OP_FETCH, src: SRC_ONES, next: StFetch},
    '{op: OP_LOAD,  src: SRC_ONES, next: StOnesRun},
    '{op: OP_RUN,   src: SRC_ONES, next: StRemLd},
    '{op: OP_LOAD,  src: SRC_REM,  next: StRemRun},
    '{op: OP_RUN,   src: SRC_REM,  next: StFin},
    '{op: OP_LOAD,  src: SRC_HDR,  next: StHdrRun},
    '{op: OP_RUN,   src: SRC_HDR,  next: StFin},
    '{op: OP_LOAD,  src: SRC_PAD,  next: StPadRun},
    '{op: OP_RUN,   src: SRC_PAD,  next: StFin},
    '{op: OP_FIN,   src: SRC_PAD,  next: StFetch}
  };

  logic [StepW-1:0] step_q, step_d;
  ctrl_word_t       word;

  assign word   = Program[step_q];
  assign ctrl_o = '{op: word.op, src: word.src};

  always_comb begin
    step_d = step_q;
    if (word.op == OP_FETCH) begin
      if (status_i.in_fire) begin
        case (status_i.mode)
          MODE_SYM: step_d = StOnesLd;
          MODE_HDR: step_d = StHdrLd;
          MODE_PAD: step_d = StPadLd;
          default:  step_d = StFin;
        endcase
      end
    end else if (status_i.advance) begin
      step_d = word.next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StFetch;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

### hw/rtl/rice_encoder_bit_packer.sv
// ----------------------------------------------------------------------------
// Rice encoder bit packer
// Rice-codes bytes, writes k headers and flush padding, packs bits LSB first.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake               Payload
// s_axis    in   tvalid / tready         tdata: mode, symbol
// m_axis    out  tvalid / tready         tdata: out_byte; tlast: last
// cfg       in   cfg_valid / cfg_ready   cfg_data: rice_k
//
// After fetch, an unused mode goes straight to finish; a header or flush item
// loads its source and runs it, and a symbol has two runs, its ones and then its
// remainder, each after its own load. Every other item then ends in finish. A run
// step appends up to the free bits of the current byte. Stalls come from the
// single output register: a completed byte waits in a pending register until
// the next one completes or the item ends, which sets tlast. Reset clears the
// bit buffer, k and all valid flags. Configuration writes are always accepted.
// ----------------------------------------------------------------------------
`include "rice_encoder_bit_packer_macros.svh"

module rice_encoder_bit_packer import rice_enc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [1:0] mode, [9:2] symbol, [15:10] zero
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] out_byte
  output logic        m_axis_tlast_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_data_i
);

  ctrl_t       ctrl;
  seq_status_t status;

  logic [2:0] k_q;
  logic [7:0] sym_q;
  logic [7:0] part_q, part_d;
  logic [2:0] fill_q, fill_d;
  logic [7:0] cnt_q, cnt_d;
  logic [7:0] word_q, word_d;
  logic       ones_q, ones_d;
  logic [7:0] pend_q, pend_d;
  logic       pend_vld_q, pend_vld_d;
  logic       out_vld_q, out_vld_d;
  logic [7:0] out_byte_q, out_byte_d;
  logic       out_last_q, out_last_d;

  logic       in_fire;
  logic       out_free;
  logic [3:0] room;
  logic [3:0] take;
  logic [8:0] mask9;
  logic [7:0] bits;
  logic [7:0] merged;
  logic       complete;
  logic       stall;
  logic       advance;
  logic [6:0] rem_rev;

  assign s_axis_tready_o = (ctrl.op == OP_FETCH);
  assign in_fire         = s_axis_tvalid_i & s_axis_tready_o;
  assign cfg_ready_o     = 1'b1;
  assign out_free        = !out_vld_q || m_axis_tready_i;

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tlast_o  = out_last_q;

  assign status = '{in_fire: in_fire, mode: s_axis_tdata_i[1:0], advance: advance};

  rice_enc_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  // Remainder bits in send order: first sent (symbol bit k-1) lands in bit 0.
  always_comb begin
    rem_rev = '0;
    for (int j = 0; j < 7; j++) begin
      if (4'(j) < {1'b0, k_q}) begin
        rem_rev[j] = sym_q[3'(k_q - 3'(j) - 3'd1)];
      end
    end
  end

  // Chunk datapath: append min(cnt, free bits) of the source at the fill point.
  assign room     = 4'd8 - {1'b0, fill_q};
  assign take     = ({4'd0, room} > cnt_q) ? cnt_q[3:0] : room;
  assign mask9    = (9'd1 << take) - 9'd1;
  assign bits     = ones_q ? 8'hFF : word_q;
  assign merged   = part_q | 8'((bits & mask9[7:0]) << fill_q);
  assign complete = (cnt_q != 8'd0) && (take == room);

  always_comb begin
    part_d     = part_q;
    fill_d     = fill_q;
    cnt_d      = cnt_q;
    word_d     = word_q;
    ones_d     = ones_q;
    pend_d     = pend_q;
    pend_vld_d = pend_vld_q;
    out_byte_d = out_byte_q;
    out_last_d = out_last_q;
    out_vld_d  = out_vld_q && !m_axis_tready_i;
    stall      = 1'b0;
    advance    = 1'b0;

    case (ctrl.op)
      OP_LOAD: begin
        advance = 1'b1;
        case (ctrl.src)
          SRC_ONES: begin
            cnt_d  = sym_q >> k_q;
            word_d = '0;
            ones_d = 1'b1;
          end
          SRC_REM: begin
            // A zero stop bit, then the remainder bits.
            cnt_d  = {4'd0, {1'b0, k_q} + 4'd1};
            word_d = {rem_rev, 1'b0};
            ones_d = 1'b0;
          end
          SRC_HDR: begin
            cnt_d  = 8'd3;
            word_d = {5'd0, k_q[0], k_q[1], k_q[2]};
            ones_d = 1'b0;
          end
          SRC_PAD: begin
            cnt_d  = {4'd0, room};
            word_d = '0;
            ones_d = 1'b1;
          end
          default: begin
            cnt_d = '0;
          end
        endcase
      end
      OP_RUN: begin
        stall   = complete && pend_vld_q && !out_free;
        advance = (cnt_q == 8'd0) || (!stall && ({4'd0, take} == cnt_q));
        if (!stall && cnt_q != 8'd0) begin
          cnt_d  = cnt_q - {4'd0, take};
          word_d = word_q >> take;
          if (complete) begin
            part_d     = '0;
            fill_d     = '0;
            pend_d     = merged;
            pend_vld_d = 1'b1;
            // Release the older byte: it is not the last of this item.
            if (pend_vld_q) begin
              out_byte_d = pend_q;
              out_last_d = 1'b0;
              out_vld_d  = 1'b1;
            end
          end else begin
            part_d = merged;
            fill_d = fill_q + take[2:0];
          end
        end
      end
      OP_FIN: begin
        stall   = pend_vld_q && !out_free;
        advance = !stall;
        if (!stall && pend_vld_q) begin
          out_byte_d = pend_q;
          out_last_d = 1'b1;
          out_vld_d  = 1'b1;
          pend_vld_d = 1'b0;
        end
      end
      default: begin
        advance = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q        <= '0;
      part_q     <= '0;
      fill_q     <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        k_q <= cfg_data_i;
      end
      part_q     <= part_d;
      fill_q     <= fill_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      sym_q <= s_axis_tdata_i[9:2];
    end
    cnt_q      <= cnt_d;
    word_q     <= word_d;
    ones_q     <= ones_d;
    pend_q     <= pend_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
  end

  `RE_ASSERT(a_pend_empty_at_fetch, s_axis_tready_o |-> !pend_vld_q, "byte pending at fetch")
  `RE_ASSERT(a_part_clean_above_fill, (part_q >> fill_q) == 8'd0, "stray bits above fill")
  `RE_ASSERT_NEXT(a_complete_pends, (ctrl.op == OP_RUN) && complete && !stall, pend_vld_q, "byte lost")
  `RE_ASSERT_NEXT(a_out_hold, out_vld_q && !m_axis_tready_i, out_vld_q && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o), "output overwritten")

endmodule
